>>> rtl/krr_pkg.sv
package krr_pkg;

   // Field widths of the request and response beats.
   localparam int KIND_BITS     = 1;
   localparam int VALUE_FIELD_BITS = 32;
   localparam int POSITION_BITS = 11;

   // Default sizing of the list.
   localparam int DEF_LIST_DEPTH = 1024;
   localparam int DEF_VALUE_BITS = 32;

   // Request kinds.
   localparam logic [KIND_BITS-1:0] KIND_LOAD   = 1'b0;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 1'b1;

   typedef struct packed {
      logic [KIND_BITS-1:0]        kind;
      logic [VALUE_FIELD_BITS-1:0] load_value;
      logic [POSITION_BITS-1:0]    position;
   } krr_req_type;

   typedef struct packed {
      logic [VALUE_FIELD_BITS-1:0] removed_value;
      logic                        error;
   } krr_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FIND,
      ST_UPDATE
   } krr_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;        // capture the request beat
      logic start_op;     // begin a load update or a remove search
      logic find_step;    // one level of the tree descent
      logic update_step;  // one node of the tree update
      logic commit;       // last update node: adjust the counters
      logic emit_err;     // load an error response
   } krr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_remove;
      logic full;
      logic rank_bad;
      logic find_last;
      logic slot_bad;
      logic update_last;
   } krr_status_type;

endpackage

>>> rtl/kth_remaining_removal_core.sv
// List of values with removal of the k-th remaining entry.
//
// A request beat (req_data) is taken at a rising edge where start is high and
// busy is low. A load beat appends load_value at the end of the list; a
// remove beat names a 1-based rank among the entries still present, and the
// block returns that entry's value and drops it. Presence is kept in a
// binary indexed count tree held in a RAM; stored values sit in a second RAM.
//
// Every remove beat, and a load into a full list, yields one response beat:
// rsp_valid is high for exactly one cycle with rsp_data. The receiver cannot
// stall, so the response must be taken in that cycle. A good load yields none.
// Flow, with L = floor(log2(LIST_DEPTH)) + 1 tree levels (11 at 1024): a
// check state, then for a remove a descent through all L levels, then an
// update of at most L tree nodes, one tree node per cycle through the tree
// RAM's single read and single write port. The response is registered after
// the last update node; an error answers from the check state or at the end
// of the descent. A new beat can be taken in the response cycle.
// Reset is synchronous. There is no clearing pass: a tree node whose first
// slot lies beyond the fill count reads as zero, so the block is ready in
// the cycle after reset is released.
module kth_remaining_removal_core
   import krr_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  krr_req_type req_data,
   output logic        rsp_valid,
   output krr_rsp_type rsp_data
);

   // Commands go one way and status the other; nothing else crosses.
   krr_cmd_type    cmd;
   krr_status_type status;

   krr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath owns both RAMs, the fill and remaining counters, the
   // descent registers and the response register.
   krr_datapath #(
      .LIST_DEPTH (LIST_DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/krr_ram.sv
module krr_ram
   import krr_pkg::*;
#(
   parameter int DEPTH = DEF_LIST_DEPTH,
   parameter int WIDTH = DEF_VALUE_BITS,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/krr_ctrl.sv
module krr_ctrl
   import krr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  krr_status_type status,
   output krr_cmd_type    cmd,
   output logic           busy,
   output logic           rsp_valid
);

   krr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.is_remove) begin
               if (status.rank_bad) begin
                  cmd.emit_err = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.start_op = 1'b1;
                  state_in     = ST_FIND;
               end
            end else if (status.full) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.start_op = 1'b1;
               state_in     = ST_UPDATE;
            end
         end
         ST_FIND: begin
            cmd.find_step = 1'b1;
            if (status.find_last) begin
               if (status.slot_bad) begin
                  cmd.emit_err = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            cmd.update_step = 1'b1;
            if (status.update_last) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.emit_err | (cmd.commit & status.is_remove);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/krr_datapath.sv
module krr_datapath
   import krr_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  krr_req_type    req_data,
   input  krr_cmd_type    cmd,
   output krr_status_type status,
   output krr_rsp_type    rsp_data
);

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int IW = $clog2(LIST_DEPTH + 1);
   localparam int XW = IW + 1;
   localparam int CW = (IW > POSITION_BITS) ? IW : POSITION_BITS;
   localparam logic [IW-1:0] DEPTH_I  = IW'(LIST_DEPTH);
   localparam logic [XW-1:0] DEPTH_X  = XW'(LIST_DEPTH);
   localparam logic [IW-1:0] TOP_STEP = {1'b1, {(IW - 1){1'b0}}};

   krr_req_type req_ff;
   krr_rsp_type rsp_ff, rsp_in;
   logic [IW-1:0] loaded_ff, loaded_in;
   logic [IW-1:0] remain_ff, remain_in;
   logic [IW-1:0] node_ff, node_in;
   logic [IW-1:0] step_ff, step_in;
   logic [CW-1:0] rank_ff, rank_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] idx_ff, idx_in;

   logic            tr_wr_en, tr_rd_en;
   logic [AW-1:0]   tr_wr_addr, tr_rd_addr;
   logic [IW-1:0]   tr_wr_data, tr_rd_data, tr_rd_idx;
   logic            vs_wr_en, vs_rd_en;
   logic [AW-1:0]   vs_rd_addr;
   logic [VALUE_BITS-1:0] vs_rd_data;

   logic          is_remove;
   logic [CW-1:0] pos_ext;
   logic [IW-1:0] cnt_eff, node_new, step_new, lowbit, upd_cur;
   logic [CW-1:0] rank_new;
   logic [XW-1:0] probe, upd_next;
   logic          take, pend_new, slot_bad, upd_ok;

   krr_ram #(.DEPTH(LIST_DEPTH), .WIDTH(IW)) u_tree_ram (
      .clock   (clock),
      .wr_en   (tr_wr_en),
      .wr_addr (tr_wr_addr),
      .wr_data (tr_wr_data),
      .rd_en   (tr_rd_en),
      .rd_addr (tr_rd_addr),
      .rd_data (tr_rd_data)
   );

   krr_ram #(.DEPTH(LIST_DEPTH), .WIDTH(VALUE_BITS)) u_value_ram (
      .clock   (clock),
      .wr_en   (vs_wr_en),
      .wr_addr (AW'(loaded_ff)),
      .wr_data (VALUE_BITS'(req_ff.load_value)),
      .rd_en   (vs_rd_en),
      .rd_addr (vs_rd_addr),
      .rd_data (vs_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         remain_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         loaded_ff <= loaded_in;
         remain_ff <= remain_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      rsp_ff  <= rsp_in;
      node_ff <= node_in;
      step_ff <= step_in;
      rank_ff <= rank_in;
      idx_ff  <= idx_in;
   end

   always_comb begin
      is_remove = (req_ff.kind == KIND_REMOVE);
      pos_ext   = CW'(req_ff.position);

      // Descent: a node whose first slot was never loaded counts as empty.
      cnt_eff  = (loaded_ff > node_ff) ? tr_rd_data : '0;
      take     = pend_ff && (CW'(cnt_eff) < rank_ff);
      node_new = take ? node_ff + step_ff : node_ff;
      rank_new = take ? rank_ff - CW'(cnt_eff) : rank_ff;
      step_new = step_ff >> 1;
      probe    = XW'(node_new) + XW'(step_new);
      pend_new = (step_new != '0) && (probe <= DEPTH_X);
      slot_bad = (node_new >= DEPTH_I);

      // Update: same rule, using the first slot covered by the node.
      lowbit   = idx_ff & (~idx_ff + IW'(1));
      upd_ok   = (loaded_ff > (idx_ff - lowbit));
      upd_cur  = upd_ok ? tr_rd_data : '0;
      upd_next = XW'(idx_ff) + XW'(lowbit);

      loaded_in = loaded_ff;
      remain_in = remain_ff;
      node_in   = node_ff;
      step_in   = step_ff;
      rank_in   = rank_ff;
      pend_in   = pend_ff;
      idx_in    = idx_ff;
      rsp_in    = rsp_ff;

      tr_rd_en   = 1'b0;
      tr_rd_idx  = '0;
      tr_wr_en   = 1'b0;
      tr_wr_data = is_remove ? upd_cur - IW'(1) : upd_cur + IW'(1);
      vs_wr_en   = 1'b0;
      vs_rd_en   = 1'b0;

      if (cmd.start_op) begin
         if (is_remove) begin
            node_in   = '0;
            step_in   = TOP_STEP;
            rank_in   = pos_ext;
            pend_in   = 1'b1;
            tr_rd_en  = 1'b1;
            tr_rd_idx = TOP_STEP;
         end else begin
            vs_wr_en  = 1'b1;
            idx_in    = loaded_ff + IW'(1);
            tr_rd_en  = 1'b1;
            tr_rd_idx = loaded_ff + IW'(1);
         end
      end

      if (cmd.find_step) begin
         node_in = node_new;
         step_in = step_new;
         rank_in = rank_new;
         pend_in = pend_new;
         if (pend_new) begin
            tr_rd_en  = 1'b1;
            tr_rd_idx = IW'(probe);
         end else if (step_new == '0 && !slot_bad) begin
            // Slot found: fetch its value and the first node to decrement.
            vs_rd_en  = 1'b1;
            idx_in    = node_new + IW'(1);
            tr_rd_en  = 1'b1;
            tr_rd_idx = node_new + IW'(1);
         end
      end

      if (cmd.update_step) begin
         tr_wr_en = 1'b1;
         if (upd_next <= DEPTH_X) begin
            idx_in    = IW'(upd_next);
            tr_rd_en  = 1'b1;
            tr_rd_idx = IW'(upd_next);
         end
      end

      if (cmd.commit) begin
         if (is_remove) begin
            remain_in = remain_ff - IW'(1);
            rsp_in.removed_value = VALUE_FIELD_BITS'(vs_rd_data);
            rsp_in.error         = 1'b0;
         end else begin
            loaded_in = loaded_ff + IW'(1);
            remain_in = remain_ff + IW'(1);
         end
      end

      if (cmd.emit_err) begin
         rsp_in.removed_value = '0;
         rsp_in.error         = 1'b1;
      end
   end

   assign tr_rd_addr = AW'(tr_rd_idx - IW'(1));
   assign tr_wr_addr = AW'(idx_ff - IW'(1));
   assign vs_rd_addr = AW'(node_new);

   assign status.is_remove   = is_remove;
   assign status.full        = (loaded_ff >= DEPTH_I);
   assign status.rank_bad    = (pos_ext == '0) || (pos_ext > CW'(remain_ff));
   assign status.find_last   = (step_new == '0);
   assign status.slot_bad    = slot_bad;
   assign status.update_last = (upd_next > DEPTH_X);

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/krr_checker.sv
module krr_checker
   import krr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input krr_rsp_type rsp_data
);

   // An accepted beat always makes the block busy in the cycle after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not make the block busy");

   // A response is a lone strobe; the next item cannot answer sooner.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   // A response only closes work that was under way.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response without a beat in progress");

   // Error responses carry a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error) |-> (rsp_data.removed_value == '0))
      else $error("error response with a nonzero value");

endmodule

bind kth_remaining_removal_core krr_checker u_krr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
